### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: command and response
// words, status codes and the per-cycle control word sent to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KEY_W    = 8;
    localparam int TAG_W    = 16;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } cmd_word_t;

    typedef struct packed {
        status_t                 status;
        logic signed [KEY_W-1:0] out_key;
        logic [TAG_W-1:0]        out_tag;
        logic [OCC_W-1:0]        occupancy;
    } rsp_word_t;

    // Broadcast to the whole chain each cycle.
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } cell_ctrl_t;

endpackage

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending key order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the word is taken on any
//   rising edge with start high and busy low. busy stays low, so one command
//   may be issued every cycle.
//   kind enqueue inserts (key, tag) after all held entries with key <= key;
//   kind dequeue removes the head (smallest key, oldest among equals).
//   Response channel: rsp is valid for exactly one cycle with done high,
//   registered at the edge that takes the command. The receiver cannot stall;
//   results must be taken in that cycle.
//   Throughput 1 command per cycle. All cells compare the new key in
//   parallel and shift one place in the same cycle, so the rate is set by
//   one key compare plus a four-way select per cell.
//   Reset (rst_n low, async) empties the queue and clears done. Cell
//   contents are not reset; slots at or above the count are never read.
//   Enqueue when full returns status full; dequeue when empty returns
//   status empty; neither changes the queue.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cmd_word_t cmd,
    output logic      done,
    output rsp_word_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    rsp_word_t        rsp_reg, rsp_next;

    logic                    accept, full, empty;
    cell_ctrl_t              ctrl;
    logic                    ins_v    [DEPTH];
    logic signed [KEY_W-1:0] key_v    [DEPTH];
    logic [TAG_W-1:0]        tag_v    [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    assign ctrl.enq = accept && (cmd.kind == KIND_ENQ) && !full;
    assign ctrl.deq = accept && (cmd.kind == KIND_DEQ) && !empty;
    assign ctrl.key = cmd.key;
    assign ctrl.tag = cmd.tag;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                    l_ins;
            logic signed [KEY_W-1:0] l_key;
            logic [TAG_W-1:0]        l_tag;
            logic                    r_has;
            logic signed [KEY_W-1:0] r_key;
            logic [TAG_W-1:0]        r_tag;

            if (i == 0)
            begin : g_head
                assign l_ins = 1'b0;
                assign l_key = '0;
                assign l_tag = '0;
            end
            else
            begin : g_mid
                assign l_ins = ins_v[i-1];
                assign l_key = key_v[i-1];
                assign l_tag = tag_v[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_has = 1'b0;
                assign r_key = '0;
                assign r_tag = '0;
            end
            else
            begin : g_body
                assign r_has = 1'b1;
                assign r_key = key_v[i+1];
                assign r_tag = tag_v[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (CNT_W'(i) < count_reg),
                .left_ins    (l_ins),
                .left_key    (l_key),
                .left_tag    (l_tag),
                .has_right   (r_has),
                .right_key   (r_key),
                .right_tag   (r_tag),
                .ins_here    (ins_v[i]),
                .key         (key_v[i]),
                .tag         (tag_v[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        done_next  = accept;
        rsp_next   = rsp_reg;
        if (accept)
        begin
            rsp_next.out_key = '0;
            rsp_next.out_tag = '0;
            unique case (cmd.kind)
                KIND_ENQ:
                begin
                    if (full)
                        rsp_next.status = ST_FULL;
                    else
                    begin
                        rsp_next.status = ST_ENQUEUED;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                KIND_DEQ:
                begin
                    if (empty)
                        rsp_next.status = ST_EMPTY;
                    else
                    begin
                        rsp_next.status  = ST_DEQUEUED;
                        rsp_next.out_key = key_v[0];
                        rsp_next.out_tag = tag_v[0];
                        count_next       = count_reg - CNT_W'(1);
                    end
                end
                default: rsp_next.status = ST_EMPTY;
            endcase
            rsp_next.occupancy = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds a key and tag; on insert it keeps its
// entry, takes the new one, or takes its left neighbor's; on removal it takes
// its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic                    occupied,
    input  logic                    left_ins,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic [TAG_W-1:0]        left_tag,
    input  logic                    has_right,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic [TAG_W-1:0]        right_tag,
    output logic                    ins_here,
    output logic signed [KEY_W-1:0] key,
    output logic [TAG_W-1:0]        tag
);

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;

    // new word lands at or before this slot; strict compare keeps FIFO order on ties
    assign ins_here = !occupied || (ctrl.key < key_reg);
    assign key      = key_reg;
    assign tag      = tag_reg;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.enq && ins_here)
        begin
            if (left_ins)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = ctrl.key;
                tag_next = ctrl.tag;
            end
        end
        else if (ctrl.deq && has_right)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_priority_queue: a directed table walks the
// empty, full, tie and extreme-key cases, then biased random bursts push the
// queue between empty and full. A shadow sorted list predicts each response the table does not fix.
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    localparam int QDEPTH = 16;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } held_t;

    typedef struct {
        cmd_word_t w;
        bit        typed;
        rsp_word_t want;
    } plan_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    cmd_word_t cmd   = '0;
    logic      busy;
    logic      done;
    rsp_word_t rsp;

    held_t     shadow[$];
    rsp_word_t awaited_rsp[$];
    plan_row_t plan[$];

    int idle_pct   = 0;
    int mismatches = 0;
    int checked    = 0;
    int n_enq      = 0;
    int n_deq      = 0;
    int n_empty    = 0;
    int n_full     = 0;
    int peak_occ   = 0;

    sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow queue: applies one command and returns the response it must give.
    function automatic rsp_word_t shadow_apply(input cmd_word_t w);
        rsp_word_t r;
        held_t     e;
        int        pos;
        r = '0;
        if (w.kind == KIND_ENQ)
        begin
            if (shadow.size() >= QDEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                pos = 0;
                // equal keys go behind the held ones
                while (pos < shadow.size() && $signed(shadow[pos].key) <= $signed(w.key))
                    pos++;
                e.key = w.key;
                e.tag = w.tag;
                shadow.insert(pos, e);
                r.status = ST_ENQUEUED;
                n_enq++;
            end
        end
        else
        begin
            if (shadow.size() == 0)
            begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                e = shadow.pop_front();
                r.status  = ST_DEQUEUED;
                r.out_key = e.key;
                r.out_tag = e.tag;
                n_deq++;
            end
        end
        r.occupancy = OCC_W'(shadow.size());
        if (shadow.size() > peak_occ)
            peak_occ = shadow.size();
        return r;
    endfunction

    function automatic cmd_word_t random_word(input bit fill);
        cmd_word_t w;
        int        pick;
        pick   = $urandom_range(99);
        w.kind = ($urandom_range(99) < (fill ? 78 : 22)) ? KIND_ENQ : KIND_DEQ;
        w.tag  = TAG_W'($urandom);
        // narrow band to force plenty of equal keys
        if (pick < 30)
            w.key = KEY_W'($urandom_range(4) - 2);
        else if (pick < 36)
            w.key = 8'h80;
        else if (pick < 42)
            w.key = 8'h7F;
        else
            w.key = KEY_W'($urandom);
        return w;
    endfunction

    task automatic add_row(input kind_t k, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag, input bit typed,
                           input status_t st, input logic [KEY_W-1:0] okey,
                           input logic [TAG_W-1:0] otag, input int occ);
        plan_row_t row;
        row.w.kind         = k;
        row.w.key          = key;
        row.w.tag          = tag;
        row.typed          = typed;
        row.want.status    = st;
        row.want.out_key   = okey;
        row.want.out_tag   = otag;
        row.want.occupancy = OCC_W'(occ);
        plan.push_back(row);
    endtask

    // start stays high across back-to-back words; it only drops for a gap
    task automatic issue_word(input cmd_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t predicted;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        predicted = shadow_apply(w);
        awaited_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at word %0d: expected %0h, got %0h",
                     what, checked, want, got);
    endtask

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
                flag("word with none awaited", 32'd0, 32'(rsp));
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status)
                    flag("status", 32'(want.status), 32'(rsp.status));
                if (rsp.out_key !== want.out_key)
                    flag("out_key", 32'(want.out_key), 32'(rsp.out_key));
                if (rsp.out_tag !== want.out_tag)
                    flag("out_tag", 32'(want.out_tag), 32'(rsp.out_tag));
                if (rsp.occupancy !== want.occupancy)
                    flag("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
            end
            checked++;
        end
    end

    initial
    begin
        int waited;
        int burst_left;
        bit fill_bias;
        burst_left = 0;
        fill_bias  = 1'b1;

        add_row(KIND_DEQ, 8'h00, 16'h0000, 1, ST_EMPTY,    8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h7F, 16'hFFFF, 1, ST_ENQUEUED, 8'h00, 16'h0000, 1);
        add_row(KIND_ENQ, 8'h80, 16'h0000, 1, ST_ENQUEUED, 8'h00, 16'h0000, 2);
        add_row(KIND_ENQ, 8'h80, 16'hAAAA, 1, ST_ENQUEUED, 8'h00, 16'h0000, 3);
        add_row(KIND_ENQ, 8'hFF, 16'h5555, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h00, 16'h8000, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        // dequeue ignores key and tag
        add_row(KIND_DEQ, 8'h7F, 16'hFFFF, 1, ST_DEQUEUED, 8'h80, 16'h0000, 4);
        add_row(KIND_DEQ, 8'h00, 16'h0000, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h80, 16'h0101, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h7F, 16'h0202, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h7F, 16'h0303, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'hFE, 16'h0404, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h03, 16'h0505, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h40, 16'h0606, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'hC0, 16'h0707, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h01, 16'h0808, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'hFF, 16'h0909, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h00, 16'h7E7E, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h64, 16'h1234, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h9C, 16'hFEDC, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        add_row(KIND_ENQ, 8'h05, 16'h8001, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);
        // queue now holds the full sixteen
        add_row(KIND_ENQ, 8'h80, 16'hFFFF, 1, ST_FULL,     8'h00, 16'h0000, QDEPTH);
        add_row(KIND_DEQ, 8'h00, 16'h0000, 0, ST_ENQUEUED, 8'h00, 16'h0000, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            issue_word(plan[i].w, plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 34 : (ph == 1) ? 56 : 0;
            for (int n = 0; n < 642; n++)
            begin
                // randomly chosen filling and draining bursts to sweep empty and full
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(8, 40);
                    fill_bias  = 1'($urandom_range(1));
                end
                burst_left--;
                issue_word(random_word(fill_bias), 1'b0, '0);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (awaited_rsp.size() != 0 && waited < 100)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (awaited_rsp.size() != 0)
            flag("words never returned", 32'd0, 32'(awaited_rsp.size()));

        $display("covered %0d words: %0d enqueues, %0d dequeues, peak occupancy %0d",
                 checked, n_enq, n_deq, peak_occ);
        $display("%0d dequeues from empty, %0d enqueues rejected full, %0d mismatches",
                 n_empty, n_full, mismatches);
        if (mismatches == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("timeout: run did not complete");
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule

### sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
test/tb.sv
